[rtl/core/cidw_pkg.sv]
`default_nettype none

package cidw_pkg;

  localparam int COORD_W  = 8;
  localparam int FRAC_W   = 16;
  localparam int WEIGHT_W = 17;
  localparam int CFG_W    = 9;
  localparam int INDEX_W  = 1;

  localparam logic [INDEX_W-1:0] REG_COLUMNS = 1'b0;
  localparam logic [INDEX_W-1:0] REG_ROWS    = 1'b1;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic write;
    logic scan;
    logic div_init;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_last;
    logic pipe_busy;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/cidw_ram.sv]
`default_nettype none

module cidw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/cidw_div.sv]
`default_nettype none

module cidw_div import cidw_pkg::*; #(
  parameter int WW = 23
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 init,
  input  wire logic                 step,
  input  wire logic [WW+FRAC_W-1:0] numer,
  input  wire logic [WW-1:0]        denom,
  output logic      [FRAC_W-1:0]    quot,
  output logic                      last
);

  localparam int CNTW = $clog2(FRAC_W);

  logic [WW-1:0]     rem;
  logic [FRAC_W-1:0] lo;
  logic [CNTW-1:0]   cnt;
  logic [WW:0]       trial;
  logic              fits;

  assign trial = {rem, lo[FRAC_W-1]};
  assign fits  = trial >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (init) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      rem <= numer[WW+FRAC_W-1:FRAC_W];
      lo  <= numer[FRAC_W-1:0];
    end else if (step) begin
      if (fits) begin
        rem <= WW'(trial - {1'b0, denom});
      end else begin
        rem <= trial[WW-1:0];
      end
      lo <= {lo[FRAC_W-2:0], fits};
    end
  end

  assign quot = lo;
  assign last = cnt == CNTW'(FRAC_W - 1);

  a_step_not_init: assert property (@(posedge clk) disable iff (rst)
    step |-> !init) else $error("divider started while stepping");

endmodule

`default_nettype wire

[rtl/core/cidw_datapath.sv]
`default_nettype none

module cidw_datapath import cidw_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int WINDOW_BACK = 5,
  parameter int ROWS_AHEAD  = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic [COORD_W-1:0] column,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic [FRAC_W-1:0]  fraction,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output logic      [FRAC_W-1:0]  average,
  output logic                    found
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_COLUMNS + 1);
  localparam int RWW    = $clog2(MAX_ROWS + 1);
  localparam int CAW    = $clog2(MAX_COLUMNS);
  localparam int RAW    = $clog2(MAX_ROWS);
  localparam int LW     = RAW + CW;
  localparam int SW0    = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int SW     = (RWW + 1 > SW0) ? RWW + 1 : SW0;
  localparam int DMAX   = (WINDOW_BACK > ROWS_AHEAD) ? WINDOW_BACK : ROWS_AHEAD;
  localparam int MW     = $clog2(DMAX + 1);
  localparam int DYW    = MW + 1;
  localparam int XW     = $clog2(WINDOW_BACK + 1);
  localparam int D2_MAX = WINDOW_BACK * WINDOW_BACK + DMAX * DMAX;
  localparam int D2W    = $clog2(D2_MAX + 1);
  localparam int NENT   = WINDOW_BACK + WINDOW_BACK * (ROWS_AHEAD + WINDOW_BACK + 1);
  localparam int WW     = $clog2(NENT * 65536 + 1);
  localparam int VW     = WW + FRAC_W;
  localparam int PW     = WEIGHT_W + FRAC_W;

  localparam logic signed [DYW-1:0] DY_LOW   = DYW'(-WINDOW_BACK);
  localparam logic signed [DYW-1:0] DY_HIGH  = DYW'(ROWS_AHEAD);
  localparam logic signed [DYW-1:0] DY_FIRST = DYW'(-1);

  logic [CFG_W-1:0] cfg_cols;
  logic [CFG_W-1:0] cfg_rows;
  logic [CW-1:0]    cols_eff;
  logic [RWW-1:0]   rows_eff;

  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic [FRAC_W-1:0]  frac_r;

  logic [XW-1:0]         dxo;
  logic signed [DYW-1:0] dy;
  logic [XW-1:0]         dxo_sel;
  logic signed [DYW-1:0] dy_sel;

  logic signed [SW-1:0] cx;
  logic signed [SW-1:0] cy;
  logic signed [SW-1:0] cols_s;
  logic signed [SW-1:0] rows_s;
  logic                 inb;
  logic [CAW-1:0]       cx_idx;
  logic [RAW-1:0]       cy_idx;
  logic [LW-1:0]        prod;
  logic [LW-1:0]        lin;
  logic [AW-1:0]        addr_c;

  logic [MW-1:0]  ady;
  logic [D2W-1:0] d2_c;

  logic [AW-1:0] clr_cnt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [FRAC_W-1:0] ram_wdata;
  logic [FRAC_W-1:0] rd_data;

  logic [WEIGHT_W-1:0] rcp_tab [D2_MAX+1];

  logic                s1_use;
  logic                s2_use;
  logic                s3_use;
  logic [AW-1:0]       s1_addr;
  logic [D2W-1:0]      s1_d2;
  logic [D2W-1:0]      s2_d2;
  logic [WEIGHT_W-1:0] w_c;
  logic [PW-1:0]       wp_c;
  logic                hit;
  logic [WEIGHT_W-1:0] s3_w;
  logic [PW-1:0]       s3_p;

  logic [WW-1:0] wsum;
  logic [VW-1:0] vsum;
  logic [VW-1:0] numer;
  logic [FRAC_W-1:0] quot;

  for (genvar g = 0; g <= D2_MAX; g++) begin : g_rcp
    localparam int DIV = (g == 0) ? 1 : g;
    localparam int RCP = (g == 0) ? 0 : (65536 + DIV / 2) / DIV;
    assign rcp_tab[g] = WEIGHT_W'(RCP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols <= CFG_W'(256);
      cfg_rows <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: cfg_cols <= cfg_data;
        REG_ROWS:    cfg_rows <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (cfg_cols == '0) begin
      cols_eff = CW'(1);
    end else if (cfg_cols > MAX_COLUMNS) begin
      cols_eff = CW'(MAX_COLUMNS);
    end else begin
      cols_eff = CW'(cfg_cols);
    end
    if (cfg_rows == '0) begin
      rows_eff = RWW'(1);
    end else if (cfg_rows > MAX_ROWS) begin
      rows_eff = RWW'(MAX_ROWS);
    end else begin
      rows_eff = RWW'(cfg_rows);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r  <= column;
      row_r  <= row;
      frac_r <= fraction;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dxo <= '0;
      dy  <= DY_FIRST;
    end else if (cmd.scan) begin
      if (dy == DY_LOW) begin
        dxo <= dxo + XW'(1);
        dy  <= DY_HIGH;
      end else begin
        dy <= dy - DYW'(1);
      end
    end
  end

  assign sts.scan_last = (dxo == XW'(WINDOW_BACK)) && (dy == DY_LOW);

  // A write uses the same address path with a zero offset.
  assign dxo_sel = cmd.write ? '0 : dxo;
  assign dy_sel  = cmd.write ? '0 : dy;

  assign cx     = $signed(SW'(col_r)) - $signed(SW'(dxo_sel));
  assign cy     = $signed(SW'(row_r)) + SW'(dy_sel);
  assign cols_s = $signed(SW'(cols_eff));
  assign rows_s = $signed(SW'(rows_eff));
  assign inb    = (cx >= 0) && (cx < cols_s) && (cy >= 0) && (cy < rows_s);

  assign cx_idx = cx[CAW-1:0];
  assign cy_idx = cy[RAW-1:0];
  assign prod   = cy_idx * cols_eff;
  assign lin    = prod + LW'(cx_idx);
  assign addr_c = lin[AW-1:0];

  assign ady  = (dy < 0) ? MW'(-dy) : MW'(dy);
  assign d2_c = D2W'(dxo) * D2W'(dxo) + D2W'(ady) * D2W'(ady);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign sts.clear_last = clr_cnt == AW'(DEPTH - 1);

  assign ram_we    = cmd.clear || (cmd.write && inb);
  assign ram_waddr = cmd.clear ? clr_cnt : addr_c;
  assign ram_wdata = cmd.clear ? '0 : frac_r;

  cidw_ram #(
    .WIDTH(FRAC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(s1_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_use <= 1'b0;
      s2_use <= 1'b0;
      s3_use <= 1'b0;
    end else begin
      s1_use <= cmd.scan && inb;
      s2_use <= s1_use;
      s3_use <= s2_use;
    end
  end

  assign w_c  = rcp_tab[s2_d2];
  assign wp_c = w_c * rd_data;
  assign hit  = s2_use && (rd_data != '0);

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      s1_addr <= addr_c;
      s1_d2   <= d2_c;
    end
    s2_d2 <= s1_d2;
    s3_w  <= hit ? w_c : '0;
    s3_p  <= hit ? wp_c : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wsum <= '0;
      vsum <= '0;
    end else if (s3_use) begin
      wsum <= wsum + WW'(s3_w);
      vsum <= vsum + VW'(s3_p);
    end
  end

  assign sts.pipe_busy = s1_use || s2_use || s3_use;

  assign numer = vsum + VW'(wsum >> 1);

  cidw_div #(
    .WW(WW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .init (cmd.div_init),
    .step (cmd.div_step),
    .numer(numer),
    .denom(wsum),
    .quot (quot),
    .last (sts.div_last)
  );

  assign found   = wsum != '0;
  assign average = found ? quot : '0;

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !sts.pipe_busy) else $error("item loaded while window reads in flight");

  a_write_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !s1_use && !s2_use) else $error("store write during window reads");

endmodule

`default_nettype wire

[rtl/core/cidw_ctrl.sv]
`default_nettype none

module cidw_ctrl import cidw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic action,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WRITE = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (action == ACT_QUERY) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_DINIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DIV) else $error("result beat without a finished divide");

  a_exclusive_cmds: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !cmd.write && !cmd.clear && !cmd.div_step)
    else $error("window scan overlaps another store or divide command");

endmodule

`default_nettype wire

[rtl/core/causal_idw_neighbour_average.sv]
// Channel   Signals                              Transfer
// command   start, busy, action, column, row,    beat when start && !busy
//           fraction
// result    done, average, found                 beat in every cycle done is high
// config    cfg_we, cfg_index, cfg_data          write when cfg_we is high
//
// After reset the store is cleared one entry per cycle, all MAX_COLUMNS * MAX_ROWS
// entries, with busy high; configuration writes are taken during that pass.
// A write beat holds busy for one cycle. A query beat holds busy while the scan
// walks NPOS = WINDOW_BACK * (WINDOW_BACK + ROWS_AHEAD + 2) positions through the
// single store read port (one window position per cycle), the pipeline drains and
// the 16-step divider runs. The result beat lasts one cycle and cannot be stalled.
`default_nettype none

module causal_idw_neighbour_average import cidw_pkg::*; #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256,
  parameter int WINDOW_BACK = 5,
  parameter int ROWS_AHEAD  = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action,
  input  wire logic [COORD_W-1:0] column,
  input  wire logic [COORD_W-1:0] row,
  input  wire logic [FRAC_W-1:0]  fraction,
  output logic                    done,
  output logic      [FRAC_W-1:0]  average,
  output logic                    found,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  cidw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .action(action),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  cidw_datapath #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS),
    .WINDOW_BACK(WINDOW_BACK),
    .ROWS_AHEAD (ROWS_AHEAD)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .column   (column),
    .row      (row),
    .fraction (fraction),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .average  (average),
    .found    (found)
  );

endmodule

`default_nettype wire
